// ===== rtl/core/pba_pkg.sv =====
// Shared types and constants of the page bitmap allocator.
package pba_pkg;

	localparam int ADDR_W      = 48;
	localparam int PAGES_OUT_W = 7;
	localparam int REG_IDX_W   = 1;

	localparam logic [PAGES_OUT_W-1:0] ALLOWED_RESET = 7'd64;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ALLOWED_PAGES = 1'b0,
		REG_BASE_ADDRESS  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_GRANTED  = 2'd0,
		ST_FULL     = 2'd1,
		ST_RELEASED = 2'd2,
		ST_INVALID  = 2'd3
	} status_t;

	typedef struct packed {
		logic capture;
		logic exec;
	} cmd_t;

endpackage

// ===== rtl/core/pba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic [WIDTH-1:0]     wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output logic [WIDTH-1:0]     rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/pba_ctrl.sv =====
// Request sequencer of the page bitmap allocator.
module pba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output pba_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign cmd.capture = (state_q == S_IDLE) && start;
	assign cmd.exec    = (state_q == S_EXEC);

endmodule

// ===== rtl/core/pba_datapath.sv =====
// Page map, counters, address checks and result registers.
module pba_datapath #(
	parameter int MAX_PAGES  = 64,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pba_pkg::cmd_t                        cmd,
	input  logic                                 wr_en,
	input  logic [pba_pkg::REG_IDX_W-1:0]        wr_index,
	input  logic [pba_pkg::ADDR_W-1:0]           wr_data,
	input  logic                                 action,
	input  logic [pba_pkg::ADDR_W-1:0]           address,
	output logic                                 done,
	output logic [1:0]                           status,
	output logic [pba_pkg::ADDR_W-1:0]           page_address,
	output logic [pba_pkg::PAGES_OUT_W-1:0]      pages_in_use
);

	localparam int AW     = pba_pkg::ADDR_W;
	localparam int PW     = pba_pkg::PAGES_OUT_W;
	localparam int WORD_W = (MAX_PAGES < 32) ? MAX_PAGES : 32;
	localparam int NROWS  = (MAX_PAGES + WORD_W - 1) / WORD_W;
	localparam int ROW_W  = (NROWS > 1) ? $clog2(NROWS) : 1;
	localparam int BIT_W  = $clog2(WORD_W);
	localparam int PIDX_W = ROW_W + BIT_W;
	localparam int CNT_W  = $clog2(MAX_PAGES + 1);
	localparam int SHIFT  = $clog2(PAGE_BYTES);
	localparam int PNUM_W = AW - SHIFT;
	localparam int CMP_W  = PNUM_W + CNT_W;
	localparam int LIM_XW = CNT_W + PW;

	// configuration
	logic [PW-1:0] allowed_q;
	logic [AW-1:0] base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allowed_q <= pba_pkg::ALLOWED_RESET;
			base_q    <= '0;
		end else if (wr_en) begin
			unique case (pba_pkg::reg_idx_t'(wr_index))
				pba_pkg::REG_ALLOWED_PAGES: allowed_q <= wr_data[PW-1:0];
				pba_pkg::REG_BASE_ADDRESS:  base_q    <= wr_data;
				default: ;
			endcase
		end
	end

	logic [LIM_XW-1:0] allowed_ext, lim_ext;
	logic [CNT_W-1:0]  lim;

	assign allowed_ext = LIM_XW'(allowed_q);
	assign lim_ext     = (allowed_ext < LIM_XW'(MAX_PAGES)) ? allowed_ext : LIM_XW'(MAX_PAGES);
	assign lim         = lim_ext[CNT_W-1:0];

	// state
	logic [NROWS-1:0] full_q;
	logic [NROWS-1:0] row_valid_q;
	logic [CNT_W-1:0] count_q;

	// capture stage: release address check, free row search, map read
	logic [AW:0]       off;
	logic              below;
	logic [PNUM_W-1:0] page_num;
	logic [SHIFT-1:0]  pg_low;
	logic              rel_ok;
	logic [PIDX_W-1:0] rel_idx;
	logic [ROW_W-1:0]  free_row;
	logic              free_any;
	logic [ROW_W-1:0]  rd_row;

	assign off      = {1'b0, address} - {1'b0, base_q};
	assign below    = off[AW];
	assign page_num = off[AW-1:SHIFT];
	assign pg_low   = off[SHIFT-1:0];
	assign rel_ok   = !below && (pg_low == '0) && (CMP_W'(page_num) < CMP_W'(lim));
	assign rel_idx  = page_num[PIDX_W-1:0];

	always_comb begin
		free_row = '0;
		free_any = 1'b0;
		for (int r = NROWS - 1; r >= 0; r--) begin
			if (!full_q[r]) begin
				free_row = ROW_W'(r);
				free_any = 1'b1;
			end
		end
	end

	assign rd_row = action ? rel_idx[PIDX_W-1:BIT_W] : free_row;

	logic             action_s1;
	logic             rel_ok_s1;
	logic             free_any_s1;
	logic [ROW_W-1:0] row_s1;
	logic [BIT_W-1:0] bit_s1;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_s1   <= action;
			rel_ok_s1   <= rel_ok;
			free_any_s1 <= free_any;
			row_s1      <= rd_row;
			bit_s1      <= rel_idx[BIT_W-1:0];
		end
	end

	// execute stage: update the map row and the count
	logic [WORD_W-1:0] rd_data;
	logic [WORD_W-1:0] word;
	logic [WORD_W-1:0] wr_word;
	logic              map_we;
	logic [BIT_W-1:0]  fbit;
	logic              fz;
	logic [PIDX_W-1:0] acq_idx;
	logic              acq_ok;
	logic [CNT_W-1:0]  cnt_nxt;
	pba_pkg::status_t  st_nxt;
	logic [AW-1:0]     pa_nxt;
	logic [CNT_W+PW-1:0] pages_w;

	pba_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NROWS)
	) u_map (
		.clk     (clk),
		.wr_en   (cmd.exec && map_we),
		.wr_addr (row_s1),
		.wr_data (wr_word),
		.rd_en   (cmd.capture),
		.rd_addr (rd_row),
		.rd_data (rd_data)
	);

	assign word = row_valid_q[row_s1] ? rd_data : '0;

	always_comb begin
		fbit = '0;
		fz   = 1'b0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (!word[b]) begin
				fbit = BIT_W'(b);
				fz   = 1'b1;
			end
		end
	end

	assign acq_idx = {row_s1, fbit};
	assign acq_ok  = free_any_s1 && fz && (count_q < lim) && (CMP_W'(acq_idx) < CMP_W'(lim));

	always_comb begin
		map_we  = 1'b0;
		wr_word = word;
		cnt_nxt = count_q;
		st_nxt  = pba_pkg::ST_FULL;
		pa_nxt  = '0;
		if (!action_s1) begin
			if (acq_ok) begin
				map_we  = 1'b1;
				wr_word = word | (WORD_W'(1) << fbit);
				cnt_nxt = count_q + CNT_W'(1);
				st_nxt  = pba_pkg::ST_GRANTED;
				pa_nxt  = base_q + (AW'(acq_idx) << SHIFT);
			end
		end else if (rel_ok_s1) begin
			st_nxt = pba_pkg::ST_RELEASED;
			if (word[bit_s1]) begin
				map_we  = 1'b1;
				wr_word = word & ~(WORD_W'(1) << bit_s1);
				if (count_q != '0) begin
					cnt_nxt = count_q - CNT_W'(1);
				end
			end
		end else begin
			st_nxt = pba_pkg::ST_INVALID;
		end
	end

	assign pages_w = (CNT_W + PW)'(cnt_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q      <= '0;
			row_valid_q <= '0;
			count_q     <= '0;
			done        <= 1'b0;
		end else begin
			done <= cmd.exec;
			if (cmd.exec) begin
				count_q <= cnt_nxt;
				if (map_we) begin
					full_q[row_s1]      <= &wr_word;
					row_valid_q[row_s1] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status       <= st_nxt;
			page_address <= pa_nxt;
			pages_in_use <= pages_w[PW-1:0];
		end
	end

endmodule

// ===== rtl/core/page_bitmap_allocator.sv =====
// Top level of the first-fit page bitmap allocator.
//
// A request is taken when start is high and busy is low: action 0 asks for
// a page, action 1 returns the page at address. After the capture and
// execute stages, done pulses for one cycle with status, page_address and
// pages_in_use; the receiver must take the beat then. busy is high only in
// the cycle after the request, so a new request may be issued in the same
// cycle as done. The capture stage checks the release address, picks the
// first map row with a free bit (per-row full flags) and issues the RAM
// read of that row or of the row to release; the execute stage sets its
// first free bit or clears the freed one, writes it back, updates the count.
// allowed_pages and base_address are written through wr_en, wr_index and
// wr_data while no request is in flight; the block leaves this to the user.
// Reset frees every page (per-row valid flags, no clearing pass), clears
// the count, sets allowed_pages to 64 and base_address to 0.
// PAGE_BYTES must be a power of two.
module page_bitmap_allocator #(
	parameter int MAX_PAGES  = 64,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [pba_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [pba_pkg::ADDR_W-1:0]       wr_data,
	input  logic                             start,
	input  logic                             action,
	input  logic [pba_pkg::ADDR_W-1:0]       address,
	output logic                             busy,
	output logic                             done,
	output logic [1:0]                       status,
	output logic [pba_pkg::ADDR_W-1:0]       page_address,
	output logic [pba_pkg::PAGES_OUT_W-1:0]  pages_in_use
);

	pba_pkg::cmd_t cmd;

	pba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	pba_datapath #(
		.MAX_PAGES  (MAX_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.action       (action),
		.address      (address),
		.done         (done),
		.status       (status),
		.page_address (page_address),
		.pages_in_use (pages_in_use)
	);

	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("request beat without result two cycles later");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != pba_pkg::ST_GRANTED) |-> (page_address == '0))
		else $error("nonzero page address without grant");

endmodule

// ===== sim/page_bitmap_allocator_checker.sv =====
// Checker for the page bitmap allocator: mirrors its page map and compares every result beat.
module page_bitmap_allocator_checker
	import pba_pkg::*;
#(
	parameter int MAX_PAGES  = 64,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [REG_IDX_W-1:0]   wr_index,
	input  logic [ADDR_W-1:0]      wr_data,
	input  logic                   start,
	input  logic                   busy,
	input  logic                   action,
	input  logic [ADDR_W-1:0]      address,
	input  logic                   done,
	input  logic [1:0]             status,
	input  logic [ADDR_W-1:0]      page_address,
	input  logic [PAGES_OUT_W-1:0] pages_in_use,
	output int                     errors,
	output int                     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t                st;
		logic [ADDR_W-1:0]      addr;
		logic [PAGES_OUT_W-1:0] cnt;
	} alloc_reply_t;

	alloc_reply_t             reply_q[$];
	logic [MAX_PAGES-1:0]     page_held = '0;
	int unsigned              held_count = 0;
	logic [PAGES_OUT_W-1:0]   limit_reg = ALLOWED_RESET;
	logic [ADDR_W-1:0]        base_reg = '0;
	int                       mismatch_count = 0;

	task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
		$display("%0t ns: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
		mismatch_count++;
	endtask

	// First-fit allocate / release against the mirrored map.
	function automatic alloc_reply_t serve_request(logic act, logic [ADDR_W-1:0] addr);
		alloc_reply_t     r;
		int unsigned      lim;
		int               idx;
		int               i;
		logic [ADDR_W-1:0] off;
		lim = (limit_reg > MAX_PAGES) ? MAX_PAGES : limit_reg;
		r.addr = '0;
		idx = -1;
		if (!act) begin
			r.st = ST_FULL;
			if (held_count < lim) begin
				for (i = lim - 1; i >= 0; i--)
					if (!page_held[i])
						idx = i;
				if (idx >= 0) begin
					page_held[idx] = 1'b1;
					held_count++;
					r.st = ST_GRANTED;
					r.addr = base_reg + ADDR_W'(idx * PAGE_BYTES);
				end
			end
		end else begin
			r.st = ST_INVALID;
			off = addr - base_reg;
			if (addr >= base_reg && 64'(off) < 64'(lim) * PAGE_BYTES &&
			    off % PAGE_BYTES == 0) begin
				idx = off / PAGE_BYTES;
				if (page_held[idx]) begin
					page_held[idx] = 1'b0;
					if (held_count > 0)
						held_count--;
				end
				r.st = ST_RELEASED;
			end
		end
		r.cnt = PAGES_OUT_W'(held_count);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_reply_t want;
		if (!arst_n) begin
			reply_q.delete();
			page_held = '0;
			held_count = 0;
			limit_reg = ALLOWED_RESET;
			base_reg = '0;
		end else begin
			if (wr_en) begin
				case (reg_idx_t'(wr_index))
					REG_ALLOWED_PAGES: limit_reg = wr_data[PAGES_OUT_W-1:0];
					REG_BASE_ADDRESS:  base_reg = wr_data;
					default: ;
				endcase
			end
			if (done) begin
				if (reply_q.size() == 0) begin
					report_mismatch("result beat with none pending", 64'd0, 64'(status));
				end else begin
					want = reply_q.pop_front();
					if (status !== want.st)
						report_mismatch("status", 64'(want.st), 64'(status));
					if (page_address !== want.addr)
						report_mismatch("page_address", 64'(want.addr), 64'(page_address));
					if (pages_in_use !== want.cnt)
						report_mismatch("pages_in_use", 64'(want.cnt), 64'(pages_in_use));
				end
			end
			if (start && !busy)
				reply_q.push_back(serve_request(action, address));
		end
		errors <= mismatch_count;
		outstanding <= reply_q.size();
	end

endmodule

// ===== sim/page_bitmap_allocator_tb.sv =====
// Testbench top of the page bitmap allocator: drives requests and register writes, gives the verdict.
module page_bitmap_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pba_pkg::*;

	localparam int MAX_PAGES  = 64;
	localparam int PAGE_BYTES = 4096;
	localparam int PHASES     = 8;
	localparam int PHASE_REQS = 205;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   wr_en = 1'b0;
	reg_idx_t               wr_index = REG_ALLOWED_PAGES;
	logic [ADDR_W-1:0]      wr_data = '0;
	logic                   start = 1'b0;
	logic                   action = 1'b0;
	logic [ADDR_W-1:0]      address = '0;
	logic                   busy;
	logic                   done;
	logic [1:0]             status;
	logic [ADDR_W-1:0]      page_address;
	logic [PAGES_OUT_W-1:0] pages_in_use;
	int                     errors;
	int                     outstanding;

	logic [PAGES_OUT_W-1:0] pool_pages = ALLOWED_RESET;
	logic [ADDR_W-1:0]      pool_base = '0;
	int                     idle_pct = 0;
	int                     reqs_sent = 0;
	int                     reg_writes = 0;

	page_bitmap_allocator #(
		.MAX_PAGES (MAX_PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.start       (start),
		.action      (action),
		.address     (address),
		.busy        (busy),
		.done        (done),
		.status      (status),
		.page_address(page_address),
		.pages_in_use(pages_in_use)
	);

	page_bitmap_allocator_checker #(
		.MAX_PAGES (MAX_PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.address     (address),
		.done        (done),
		.status      (status),
		.page_address(page_address),
		.pages_in_use(pages_in_use),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always #6 clk = ~clk;

	initial begin
		#2ms;
		$display("page_bitmap_allocator_tb NOT OK");
		$finish;
	end

	// Drain all pending beats, then let the pipeline settle.
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [ADDR_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		reg_writes++;
	endtask

	task automatic set_pool(logic [PAGES_OUT_W-1:0] pages, logic [ADDR_W-1:0] new_base);
		logic [ADDR_W-1:0] data;
		wait_idle();
		data = {$urandom, $urandom};
		data[PAGES_OUT_W-1:0] = pages;
		if ($urandom_range(1)) begin
			write_reg(REG_ALLOWED_PAGES, data);
			write_reg(REG_BASE_ADDRESS, new_base);
		end else begin
			write_reg(REG_BASE_ADDRESS, new_base);
			write_reg(REG_ALLOWED_PAGES, data);
		end
		pool_pages = pages;
		pool_base = new_base;
	endtask

	task automatic send(logic act, logic [ADDR_W-1:0] addr);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		address <= addr;
		do
			@(posedge clk);
		while (busy);
		reqs_sent++;
	endtask

	task automatic send_random();
		int                lim;
		int                pick;
		int                pg;
		logic [ADDR_W-1:0] addr;
		lim = (pool_pages > MAX_PAGES) ? MAX_PAGES : pool_pages;
		pick = $urandom_range(99);
		pg = (lim > 0) ? $urandom_range(lim - 1) : 0;
		if ($urandom_range(9) == 0)
			pg = $urandom_range(MAX_PAGES + 1);
		addr = pool_base + ADDR_W'(pg * PAGE_BYTES);
		if (pick < 50)
			send(1'b0, {$urandom, $urandom});
		else if (pick < 85)
			send(1'b1, addr);
		else if (pick < 92)
			send(1'b1, addr + ADDR_W'($urandom_range(1, PAGE_BYTES - 1)));
		else
			send(1'b1, {$urandom, $urandom});
	endtask

	initial begin
		logic [PAGES_OUT_W-1:0] pages;
		logic [ADDR_W-1:0]      phase_base;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset pool: 64 pages at address zero
		send(1'b0, '0);
		send(1'b0, '1);
		send(1'b0, '0);
		send(1'b1, 48'h1000);
		send(1'b0, '0);
		send(1'b1, 48'h5000);
		send(1'b1, 48'h1001);
		send(1'b1, 48'h40000);
		send(1'b1, 48'hFFFF_FFFF_FFFF);

		// limit lowered below the held pages, base near the top
		set_pool(7'd2, 48'hFFFF_FFFF_E000);
		send(1'b0, '0);
		send(1'b1, 48'hFFFF_FFFF_E000);
		send(1'b0, '0);
		send(1'b1, 48'h0);
		send(1'b1, 48'hFFFF_FFFF_F000);
		send(1'b0, '0);

		// zero limit
		set_pool(7'd0, 48'h3000);
		send(1'b0, '0);
		send(1'b1, 48'h3000);

		// limit above the map size, granted addresses wrap
		set_pool(7'd127, 48'hFFFF_FFFF_F000);
		send(1'b0, '0);
		send(1'b0, '0);
		send(1'b1, 48'h2000);
		send(1'b1, 48'h1000);
		send(1'b1, 48'hFFFF_FFFF_FFFF);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: pages = 7'd1;
				1: pages = 7'd64;
				2: pages = 7'd2;
				3: pages = 7'd0;
				4: pages = 7'd65;
				5: pages = 7'($urandom_range(3, 16));
				6: pages = 7'd127;
				default: pages = 7'($urandom_range(1, 64));
			endcase
			case (ph % 4)
				0: phase_base = '0;
				1: phase_base = 48'hFFFF_FFFF_F000;
				2: phase_base = {$urandom, $urandom} & ~ADDR_W'(PAGE_BYTES - 1);
				default: phase_base = {$urandom, $urandom};
			endcase
			set_pool(pages, phase_base);
			idle_pct = (ph == PHASES - 1) ? 0 : (ph % 3) * 30;
			repeat (PHASE_REQS) send_random();
		end

		wait_idle();
		repeat (4) @(posedge clk);
		$display("%0d requests sent across %0d register writes,", reqs_sent, reg_writes);
		$display("pool limits 0 to 127 with bases at zero, near the top and random.");
		if (errors == 0 && outstanding == 0)
			$display("page_bitmap_allocator_tb OK");
		else
			$display("page_bitmap_allocator_tb NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/pba_pkg.sv
rtl/core/pba_ram.sv
rtl/core/pba_ctrl.sv
rtl/core/pba_datapath.sv
rtl/core/page_bitmap_allocator.sv
sim/page_bitmap_allocator_checker.sv
sim/page_bitmap_allocator_tb.sv
